[rtl/core/jpegzip_pkg.sv]
package jpegzip_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned VERDICT_W = 3;
    localparam int unsigned OFFSET_W  = 32;
    localparam int unsigned SEGLEN_W  = 16;
    localparam int unsigned OUT_W     = 40;   // verdict + offset, padded to whole bytes

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_NOT_JPEG   = 3'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_NO_TRAILER = 3'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_ZIP        = 3'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_OTHER      = 3'd3;
    localparam logic [VERDICT_W-1:0] VERDICT_WALK_ERROR = 3'd4;

    // marker codes
    localparam logic [15:0] MARK_SOI  = 16'hFFD8;
    localparam logic [15:0] MARK_EOI  = 16'hFFD9;
    localparam logic [15:0] MARK_SOS  = 16'hFFDA;
    localparam logic [15:0] MARK_FILL = 16'hFFFF;

    localparam logic [31:0] ZIP_LFH_SIG = 32'h04034B50;

    localparam logic [BYTE_W-1:0] MAX_MARKERS_RESET = 8'd12;

endpackage

[rtl/core/jpeg_end_and_appended_zip_detector_unit.sv]
// jpeg end finder with appended-zip detector
//
// s_* channel: one file byte per request, s_tlast on the final byte of a file.
// m_* channel: at most one verdict per file, with the offset just past the
//   end-of-image marker (zero for "not jpeg" and "walk error").
// cfg_* channel: writes max_markers; the user must write only while the block is idle, the block does not enforce it.
//
// a byte accepted into the input register is processed when the result
// register is free or draining; its verdict (if any) then shows on m_tvalid.
// throughput: one byte per cycle while the receiver takes verdicts, set by the
// single state update between the input register and the result register.
//
// reset puts max_markers back to 12 and the parser at the start of a file.
// when the receiver stalls with a verdict pending, the parser holds: a byte
// already in the input register waits there with s_tready low, and an empty
// input register takes one more byte before s_tready drops, until the
// verdict is taken.
module jpeg_end_and_appended_zip_detector_unit
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] data_byte
    input  logic        s_tlast,      // last_byte

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,      // [2:0] verdict, [34:3] jpeg_end_offset, [39:35] zero

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data      // [7:0] max_markers
);

    // parser phases
    typedef enum logic [3:0] {
        PH_START0,
        PH_START1,
        PH_MHI,
        PH_MLO,
        PH_LENHI,
        PH_LENLO,
        PH_SKIP,
        PH_SOSPAD,
        PH_SCAN,
        PH_TRAIL,
        PH_DONE
    } phase_t;

    localparam int unsigned BW = jpegzip_pkg::BYTE_W;
    localparam int unsigned VW = jpegzip_pkg::VERDICT_W;
    localparam int unsigned OW = jpegzip_pkg::OFFSET_W;
    localparam int unsigned LW = jpegzip_pkg::SEGLEN_W;

    // configuration
    logic [BW-1:0] max_markers_reg;

    // input register
    logic          in_valid_reg;
    logic [BW-1:0] in_data_reg;
    logic          in_last_reg;

    // parser state
    phase_t        phase_reg, phase_next;
    logic [OW-1:0] byte_position_reg, byte_position_next;
    logic [LW-1:0] skip_remaining_reg, skip_remaining_next;
    logic [BW-1:0] held_byte_reg, held_byte_next;
    logic [BW-1:0] marker_reads_reg, marker_reads_next;
    logic [31:0]   trailer_shift_reg, trailer_shift_next;
    logic [OW-1:0] end_offset_reg, end_offset_next;
    logic          verdict_given_reg, verdict_given_next;

    // result register
    logic          out_valid_reg;
    logic [VW-1:0] out_verdict_reg;
    logic [OW-1:0] out_offset_reg;

    logic          advance;
    logic          res_valid;
    logic [VW-1:0] res_verdict;
    logic [OW-1:0] res_offset;
    logic [OW-1:0] past;
    logic [15:0]   marker;
    logic [LW-1:0] seg_len;
    logic [31:0]   trailer_full;

    // the processing stage moves whenever the result slot is free or draining
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_offset_reg, out_verdict_reg};

    assign past    = (byte_position_reg == {OW{1'b1}}) ? byte_position_reg
                                                       : byte_position_reg + 1'b1;
    assign marker  = {held_byte_reg, in_data_reg};
    assign seg_len = {held_byte_reg, in_data_reg};
    // fourth trailer byte lands in the top lane
    assign trailer_full = {in_data_reg, trailer_shift_reg[23:0]};

    always_comb
    begin
        phase_next          = phase_reg;
        byte_position_next  = byte_position_reg;
        skip_remaining_next = skip_remaining_reg;
        held_byte_next      = held_byte_reg;
        marker_reads_next   = marker_reads_reg;
        trailer_shift_next  = trailer_shift_reg;
        end_offset_next     = end_offset_reg;
        verdict_given_next  = verdict_given_reg;
        res_valid           = 1'b0;
        res_verdict         = jpegzip_pkg::VERDICT_NOT_JPEG;
        res_offset          = '0;

        if (in_valid_reg)
        begin
            case (phase_reg)
                PH_START0:
                begin
                    if (in_data_reg == jpegzip_pkg::MARK_SOI[15:8])
                    begin
                        phase_next = PH_START1;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
                PH_START1:
                begin
                    if (in_data_reg == jpegzip_pkg::MARK_SOI[7:0])
                    begin
                        phase_next = PH_MHI;
                    end
                    else
                    begin
                        res_valid = 1'b1;
                    end
                end
                PH_MHI:
                begin
                    held_byte_next = in_data_reg;
                    phase_next     = PH_MLO;
                end
                PH_MLO:
                begin
                    if (marker_reads_reg >= max_markers_reg)
                    begin
                        res_valid   = 1'b1;
                        res_verdict = jpegzip_pkg::VERDICT_WALK_ERROR;
                    end
                    else
                    begin
                        marker_reads_next = marker_reads_reg + 1'b1;
                        if (marker == jpegzip_pkg::MARK_FILL)
                        begin
                            // fill byte: the second ff becomes the new marker prefix
                            held_byte_next = 8'hFF;
                        end
                        else if (marker == jpegzip_pkg::MARK_EOI)
                        begin
                            end_offset_next = past;
                            if (in_last_reg)
                            begin
                                res_valid   = 1'b1;
                                res_verdict = jpegzip_pkg::VERDICT_NO_TRAILER;
                                res_offset  = past;
                            end
                            else
                            begin
                                trailer_shift_next  = '0;
                                skip_remaining_next = '0;
                                phase_next          = PH_TRAIL;
                            end
                        end
                        else if (marker == jpegzip_pkg::MARK_SOS)
                        begin
                            phase_next = PH_SOSPAD;
                        end
                        else
                        begin
                            phase_next = PH_LENHI;
                        end
                    end
                end
                PH_LENHI:
                begin
                    held_byte_next = in_data_reg;
                    phase_next     = PH_LENLO;
                end
                PH_LENLO:
                begin
                    // segment length counts its own two bytes
                    if (seg_len < LW'(2))
                    begin
                        res_valid   = 1'b1;
                        res_verdict = jpegzip_pkg::VERDICT_WALK_ERROR;
                    end
                    else if (seg_len == LW'(2))
                    begin
                        phase_next = PH_MHI;
                    end
                    else
                    begin
                        skip_remaining_next = seg_len - LW'(2);
                        phase_next          = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    skip_remaining_next = skip_remaining_reg - 1'b1;
                    if (skip_remaining_reg == LW'(1))
                    begin
                        phase_next = PH_MHI;
                    end
                end
                PH_SOSPAD:
                begin
                    // byte after the scan marker is passed over
                    held_byte_next = '0;
                    phase_next     = PH_SCAN;
                end
                PH_SCAN:
                begin
                    if (marker == jpegzip_pkg::MARK_EOI)
                    begin
                        end_offset_next = past;
                        if (in_last_reg)
                        begin
                            res_valid   = 1'b1;
                            res_verdict = jpegzip_pkg::VERDICT_NO_TRAILER;
                            res_offset  = past;
                        end
                        else
                        begin
                            trailer_shift_next  = '0;
                            skip_remaining_next = '0;
                            phase_next          = PH_TRAIL;
                        end
                    end
                    else
                    begin
                        held_byte_next = in_data_reg;
                    end
                end
                PH_TRAIL:
                begin
                    case (skip_remaining_reg[1:0])
                        2'd0:    trailer_shift_next[7:0]   = in_data_reg;
                        2'd1:    trailer_shift_next[15:8]  = in_data_reg;
                        2'd2:    trailer_shift_next[23:16] = in_data_reg;
                        default: trailer_shift_next[31:24] = in_data_reg;
                    endcase
                    skip_remaining_next = skip_remaining_reg + 1'b1;
                    if (skip_remaining_reg == LW'(3))
                    begin
                        res_valid   = 1'b1;
                        res_verdict = (trailer_full == jpegzip_pkg::ZIP_LFH_SIG)
                                      ? jpegzip_pkg::VERDICT_ZIP
                                      : jpegzip_pkg::VERDICT_OTHER;
                        res_offset  = end_offset_reg;
                    end
                end
                default:
                begin
                end
            endcase

            if (res_valid)
            begin
                verdict_given_next = 1'b1;
                phase_next         = PH_DONE;
            end

            byte_position_next = past;

            if (in_last_reg)
            begin
                // file ends without a verdict: decide from where the walk stopped
                if (!res_valid && !verdict_given_reg)
                begin
                    res_valid = 1'b1;
                    if (phase_next == PH_START0 || phase_next == PH_START1)
                    begin
                        res_verdict = jpegzip_pkg::VERDICT_NOT_JPEG;
                    end
                    else if (phase_next == PH_TRAIL)
                    begin
                        res_verdict = jpegzip_pkg::VERDICT_OTHER;
                        res_offset  = end_offset_next;
                    end
                    else
                    begin
                        res_verdict = jpegzip_pkg::VERDICT_WALK_ERROR;
                    end
                end
                phase_next          = PH_START0;
                byte_position_next  = '0;
                skip_remaining_next = '0;
                held_byte_next      = '0;
                marker_reads_next   = '0;
                trailer_shift_next  = '0;
                end_offset_next     = '0;
                verdict_given_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_markers_reg    <= jpegzip_pkg::MAX_MARKERS_RESET;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
            phase_reg          <= PH_START0;
            byte_position_reg  <= '0;
            skip_remaining_reg <= '0;
            held_byte_reg      <= '0;
            marker_reads_reg   <= '0;
            trailer_shift_reg  <= '0;
            end_offset_reg     <= '0;
            verdict_given_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                max_markers_reg <= cfg_data;
            end

            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end

            // a new result replaces the one draining in the same cycle
            if (advance)
            begin
                out_valid_reg <= res_valid;
            end
            else if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                phase_reg          <= phase_next;
                byte_position_reg  <= byte_position_next;
                skip_remaining_reg <= skip_remaining_next;
                held_byte_reg      <= held_byte_next;
                marker_reads_reg   <= marker_reads_next;
                trailer_shift_reg  <= trailer_shift_next;
                end_offset_reg     <= end_offset_next;
                verdict_given_reg  <= verdict_given_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && res_valid)
        begin
            out_verdict_reg <= res_verdict;
            out_offset_reg  <= res_offset;
        end
    end

    // verdict codes stay within the defined set
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[2:0] <= jpegzip_pkg::VERDICT_WALK_ERROR))
        else $error("verdict code out of range");

    // rejected or broken files carry no end offset
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[2:0] == jpegzip_pkg::VERDICT_NOT_JPEG ||
                      m_tdata[2:0] == jpegzip_pkg::VERDICT_WALK_ERROR))
        |-> (m_tdata[34:3] == '0))
        else $error("offset given with a failing verdict");

    // a final byte always returns the parser to the start of a file
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg)
        |=> (phase_reg == PH_START0 && byte_position_reg == '0 && !verdict_given_reg))
        else $error("parser not cleared after final byte");

    // once a verdict is out the parser only waits for the final byte
    assert property (@(posedge clk) disable iff (!rst_n)
        verdict_given_reg |-> (phase_reg == PH_DONE))
        else $error("verdict given but parser still walking");

endmodule

[bench/jpeg_end_and_appended_zip_detector_unit_tb.sv]
`timescale 1ns / 100ps

module jpeg_end_and_appended_zip_detector_unit_tb;

    // one file byte as it goes onto the slave channel
    typedef struct {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    // one verdict as it leaves on m_tdata, offset above the code
    typedef struct packed {
        logic [31:0] offset;
        logic [2:0]  code;
    } verdict_t;

    // where the marker walk stands inside the current file
    typedef enum logic [3:0] {
        P_SOI_HI,
        P_SOI_LO,
        P_MARK_HI,
        P_MARK_LO,
        P_LEN_HI,
        P_LEN_LO,
        P_SKIP,
        P_SOS_PAD,
        P_SCAN,
        P_TRAIL,
        P_DONE
    } walk_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;    // [7:0] data_byte
    logic        s_tlast = 1'b0;     // last_byte

    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;            // [2:0] verdict, [34:3] jpeg_end_offset, [39:35] zero

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'h00;   // [7:0] max_markers

    // byte requests waiting for the driver, verdicts waiting for the block
    byte_req_t   byte_reqs[$];
    verdict_t    verdicts_due[$];
    logic [7:0]  file_bytes[$];

    // predicted walk state, one copy of the block's registers
    logic [7:0]  max_q = jpegzip_pkg::MAX_MARKERS_RESET;
    walk_phase_t ph_q = P_SOI_HI;
    logic [31:0] pos_q = '0;
    logic [15:0] seg_left_q = '0;
    logic [7:0]  held_q = '0;
    logic [7:0]  reads_q = '0;
    logic [31:0] trail_q = '0;
    logic [31:0] img_end_q = '0;
    logic        given_q = 1'b0;

    bit          idle_on = 1'b1;
    int          gap_left = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          bytes_queued = 0;
    int          files_queued = 0;
    int          verdicts_checked = 0;
    int          settings_used = 1;

    jpeg_end_and_appended_zip_detector_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 20 ns period
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // verdict prediction
    // ------------------------------------------------------------------

    // a verdict closes the file until its final byte
    function automatic void post_verdict(input logic [2:0] code, input logic [31:0] off);
        verdicts_due.push_back('{offset: off, code: code});
        given_q = 1'b1;
        ph_q = P_DONE;
    endfunction

    // end-of-image seen, either in the walk or inside scan data
    function automatic void mark_image_end(input logic [31:0] off, input logic fin);
        img_end_q = off;
        if (fin)
            post_verdict(jpegzip_pkg::VERDICT_NO_TRAILER, off);
        else
        begin
            trail_q = '0;
            seg_left_q = '0;
            ph_q = P_TRAIL;
        end
    endfunction

    // advance the walk by one accepted byte, queueing any verdict it yields
    function automatic void parse_byte(input logic [7:0] b, input logic fin);
        logic [31:0] past;
        logic [15:0] pair;
        past = (pos_q == 32'hFFFF_FFFF) ? pos_q : pos_q + 32'd1;
        case (ph_q)
            P_SOI_HI:
                if (b == jpegzip_pkg::MARK_SOI[15:8])
                    ph_q = P_SOI_LO;
                else
                    post_verdict(jpegzip_pkg::VERDICT_NOT_JPEG, '0);
            P_SOI_LO:
                if (b == jpegzip_pkg::MARK_SOI[7:0])
                    ph_q = P_MARK_HI;
                else
                    post_verdict(jpegzip_pkg::VERDICT_NOT_JPEG, '0);
            P_MARK_HI:
            begin
                held_q = b;
                ph_q = P_MARK_LO;
            end
            P_MARK_LO:
            begin
                pair = {held_q, b};
                // the read past the allowed count is the error, not the one at it
                if (reads_q >= max_q)
                    post_verdict(jpegzip_pkg::VERDICT_WALK_ERROR, '0);
                else
                begin
                    reads_q++;
                    if (pair == jpegzip_pkg::MARK_FILL)
                        held_q = 8'hFF;     // fill byte, the low byte comes next
                    else if (pair == jpegzip_pkg::MARK_EOI)
                        mark_image_end(past, fin);
                    else if (pair == jpegzip_pkg::MARK_SOS)
                        ph_q = P_SOS_PAD;
                    else
                        ph_q = P_LEN_HI;
                end
            end
            P_LEN_HI:
            begin
                held_q = b;
                ph_q = P_LEN_LO;
            end
            P_LEN_LO:
            begin
                pair = {held_q, b};     // segment length, counts its own two bytes
                if (pair < 16'd2)
                    post_verdict(jpegzip_pkg::VERDICT_WALK_ERROR, '0);
                else if (pair == 16'd2)
                    ph_q = P_MARK_HI;
                else
                begin
                    seg_left_q = pair - 16'd2;
                    ph_q = P_SKIP;
                end
            end
            P_SKIP:
            begin
                seg_left_q--;
                if (seg_left_q == '0)
                    ph_q = P_MARK_HI;
            end
            P_SOS_PAD:
            begin
                // first byte after start-of-scan is passed over
                held_q = '0;
                ph_q = P_SCAN;
            end
            P_SCAN:
                if (held_q == jpegzip_pkg::MARK_EOI[15:8] && b == jpegzip_pkg::MARK_EOI[7:0])
                    mark_image_end(past, fin);
                else
                    held_q = b;
            P_TRAIL:
            begin
                // trailer bytes land first byte lowest, compared as a word
                trail_q |= 32'(b) << {seg_left_q[1:0], 3'b000};
                seg_left_q++;
                if (seg_left_q >= 16'd4)
                    post_verdict((trail_q == jpegzip_pkg::ZIP_LFH_SIG)
                                 ? jpegzip_pkg::VERDICT_ZIP : jpegzip_pkg::VERDICT_OTHER,
                                 img_end_q);
            end
            default:
                ;
        endcase
        pos_q = past;
        if (fin)
        begin
            // final byte forces a verdict if none came yet, then a fresh file
            if (!given_q)
            begin
                if (ph_q == P_SOI_HI || ph_q == P_SOI_LO)
                    post_verdict(jpegzip_pkg::VERDICT_NOT_JPEG, '0);
                else if (ph_q == P_TRAIL)
                    post_verdict(jpegzip_pkg::VERDICT_OTHER, img_end_q);
                else
                    post_verdict(jpegzip_pkg::VERDICT_WALK_ERROR, '0);
            end
            ph_q = P_SOI_HI;
            pos_q = '0;
            seg_left_q = '0;
            held_q = '0;
            reads_q = '0;
            trail_q = '0;
            img_end_q = '0;
            given_q = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // file building
    // ------------------------------------------------------------------

    function automatic void put(input logic [7:0] b);
        file_bytes.push_back(b);
    endfunction

    function automatic void start_image();
        put(jpegzip_pkg::MARK_SOI[15:8]);
        put(jpegzip_pkg::MARK_SOI[7:0]);
    endfunction

    // marker with optional fill bytes between the lead byte and the code
    function automatic void add_marker(input logic [7:0] code, input int fills);
        put(8'hFF);
        repeat (fills) put(8'hFF);
        put(code);
    endfunction

    function automatic void put_zip_sig();
        put(jpegzip_pkg::ZIP_LFH_SIG[7:0]);
        put(jpegzip_pkg::ZIP_LFH_SIG[15:8]);
        put(jpegzip_pkg::ZIP_LFH_SIG[23:16]);
        put(jpegzip_pkg::ZIP_LFH_SIG[31:24]);
    endfunction

    // hand the built file to the driver, tlast on its final byte
    function automatic void queue_file();
        foreach (file_bytes[i])
            byte_reqs.push_back('{data: file_bytes[i], last: (i == file_bytes.size() - 1)});
        bytes_queued += file_bytes.size();
        files_queued++;
        file_bytes.delete();
    endfunction

    // mostly well-formed images with random content, some noise and damage
    task automatic queue_random_file();
        int         r;
        int         pick;
        int         len;
        int         fills;
        int         idx;
        logic [7:0] code;
        logic [7:0] prev;
        logic [7:0] b;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            // noise, sometimes with a plausible first byte
            repeat ($urandom_range(1, 6)) put(8'($urandom));
            if ($urandom_range(0, 1) == 1)
                file_bytes[0] = 8'hFF;
        end
        else
        begin
            start_image();
            repeat ($urandom_range(0, 6))
            begin
                fills = ($urandom_range(0, 5) == 0) ? int'($urandom_range(1, 2)) : 0;
                do
                    code = 8'($urandom);
                while (code == jpegzip_pkg::MARK_EOI[7:0] || code == jpegzip_pkg::MARK_SOS[7:0]
                       || code == 8'hFF);
                add_marker(code, fills);
                // mostly short segments, now and then a bad length or a long one
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    len = $urandom_range(0, 1);
                else if (pick == 1)
                    len = $urandom_range(100, 400);
                else
                    len = $urandom_range(2, 12);
                put(len[15:8]);
                put(len[7:0]);
                if (len > 2)
                    repeat (len - 2) put(8'($urandom));
            end
            pick = $urandom_range(0, 9);
            if (pick < 6)
            begin
                add_marker(jpegzip_pkg::MARK_SOS[7:0], 0);
                put(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
                prev = 8'h00;
                repeat ($urandom_range(0, 24))
                begin
                    b = ($urandom_range(0, 5) == 0) ? 8'hFF : 8'($urandom);
                    if (prev == 8'hFF && b == jpegzip_pkg::MARK_EOI[7:0])
                        b = 8'h00;      // keep the real end where it is placed
                    put(b);
                    prev = b;
                end
                put(8'hFF);
                put(jpegzip_pkg::MARK_EOI[7:0]);
            end
            else if (pick < 9)
                add_marker(jpegzip_pkg::MARK_EOI[7:0], ($urandom_range(0, 4) == 0) ? 1 : 0);
            // otherwise no end marker at all, the stream runs out early
            if (pick < 9)
            begin
                case ($urandom_range(0, 3))
                    0: ;
                    1:
                    begin
                        put_zip_sig();
                        repeat ($urandom_range(0, 4)) put(8'($urandom));
                    end
                    2:
                    begin
                        // signature off by one bit
                        put_zip_sig();
                        idx = file_bytes.size() - 1 - int'($urandom_range(0, 3));
                        file_bytes[idx] ^= 8'(1 << $urandom_range(0, 7));
                    end
                    default:
                        repeat ($urandom_range(1, 6)) put(8'($urandom));
                endcase
            end
        end
        if (r == 1)
        begin
            // damage: one byte overwritten or the file cut short
            idx = $urandom_range(0, file_bytes.size() - 1);
            if ($urandom_range(0, 1) == 1)
                file_bytes[idx] = 8'($urandom);
            else
                while (file_bytes.size() > idx + 1)
                    void'(file_bytes.pop_back());
        end
        queue_file();
    endtask

    // ------------------------------------------------------------------
    // handshake pacing and reporting
    // ------------------------------------------------------------------

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        if (!idle_on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100)
            $display("%0t: %s mismatch, got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // wait until no request is queued or in flight and no verdict is due,
    // then let the block settle before touching the register
    task automatic wait_idle();
        int waited;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while ((byte_reqs.size() != 0 || s_tvalid || verdicts_due.size() != 0)
               && waited < 100000);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_max_markers(input logic [7:0] value);
        @(posedge clk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_q = value;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // slave side driver: one byte request at a time from byte_reqs
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : byte_driver
        byte_req_t req;
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            // request taken at this edge goes through the predictor
            if (s_tvalid && s_tready)
                parse_byte(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (byte_reqs.size() != 0)
                begin
                    req = byte_reqs.pop_front();
                    s_tdata <= req.data;
                    s_tlast <= req.last;
                    s_tvalid <= 1'b1;
                    gap_left = pick_idle();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // master side monitor: random back-pressure, field-by-field check
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : verdict_monitor
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            verdicts_checked++;
            if (verdicts_due.size() == 0)
                report_mismatch("unexpected verdict", 32'(m_tdata[2:0]), '0);
            else
            begin
                want = verdicts_due.pop_front();
                if (m_tdata[2:0] !== want.code)
                    report_mismatch("verdict", 32'(m_tdata[2:0]), 32'(want.code));
                if (m_tdata[34:3] !== want.offset)
                    report_mismatch("jpeg end offset", m_tdata[34:3], want.offset);
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left = pick_idle();
        end
    end

    // ------------------------------------------------------------------
    // stimulus: directed files at the reset setting, then random phases
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int         phase_no;
        int         budget;
        logic [7:0] setting;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // not a start marker, with a byte after the verdict that is ignored
        put(8'h12);
        put(8'h34);
        queue_file();
        // a file that is a single lead byte
        put(8'hFF);
        queue_file();
        // segment length below two
        start_image();
        add_marker(8'hC0, 0);
        put(8'h00);
        put(8'h01);
        queue_file();
        // end pair hidden in the skipped byte after start-of-scan, real end in
        // scan data, then a one byte trailer
        start_image();
        add_marker(jpegzip_pkg::MARK_SOS[7:0], 0);
        put(8'hFF);
        put(jpegzip_pkg::MARK_EOI[7:0]);
        put(8'hFF);
        put(jpegzip_pkg::MARK_EOI[7:0]);
        put(8'hAB);
        queue_file();
        // fill byte before the end marker, zip header right behind it
        start_image();
        add_marker(jpegzip_pkg::MARK_EOI[7:0], 1);
        put_zip_sig();
        queue_file();

        for (phase_no = 0; phase_no < 7; phase_no++)
        begin
            if (phase_no > 0)
            begin
                case (phase_no)
                    1: setting = 8'd255;
                    2: setting = 8'd1;
                    3: setting = 8'd0;
                    4: setting = 8'($urandom_range(2, 20));
                    5: setting = 8'($urandom_range(1, 255));
                    default: setting = jpegzip_pkg::MAX_MARKERS_RESET;
                endcase
                wait_idle();
                write_max_markers(setting);
                @(negedge clk);
            end
            // every third phase runs with no gaps and no stalls
            idle_on = (phase_no % 3 != 2);
            budget = bytes_queued + 150;
            while (bytes_queued < budget)
                queue_random_file();
        end

        wait_idle();
        while (verdicts_due.size() != 0)
        begin
            want_leftover : begin
                verdict_t left;
                left = verdicts_due.pop_front();
                report_mismatch("missing verdict", '0, 32'(left.code));
            end
        end

        $display("streamed %0d bytes in %0d files under %0d max_markers settings",
                 bytes_queued, files_queued, settings_used);
        $display("checked %0d verdicts, %0d mismatches", verdicts_checked, mismatches);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
